/* design/lhist_pkg.sv */
package lhist_pkg;

   localparam int MAX_LEVELS  = 64;
   localparam int COUNT_BITS  = 24;

   localparam int CHAN_W      = 8;
   localparam int LVL_W       = 7;
   localparam int IDX_W       = $clog2(MAX_LEVELS);
   localparam int OUT_COUNT_W = 24;
   localparam int OUT_IDX_W   = 6;
   localparam int LUMA_W      = 24;
   localparam int FRAC_W      = 16;
   localparam int PROD_W      = LUMA_W + LVL_W;
   localparam int QUO_W       = PROD_W - FRAC_W;
   localparam int EST_W       = QUO_W - CHAN_W;

   localparam logic [LUMA_W-1:0] WEIGHT_RED   = LUMA_W'(13938);
   localparam logic [LUMA_W-1:0] WEIGHT_GREEN = LUMA_W'(46870);
   localparam logic [LUMA_W-1:0] WEIGHT_BLUE  = LUMA_W'(4730);
   localparam logic [QUO_W-1:0]  CHAN_FULL    = QUO_W'(255);

   localparam logic [LVL_W-1:0]      LEVELS_RESET = LVL_W'(64);
   localparam logic [LVL_W-1:0]      LEVELS_TOP   = LVL_W'(MAX_LEVELS);
   localparam logic [COUNT_BITS-1:0] COUNT_TOP    = {COUNT_BITS{1'b1}};
   localparam logic [COUNT_BITS-1:0] PEAK_RESET   = COUNT_BITS'(1);

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic              last_pixel;
   } pixel_type;

   typedef struct packed {
      logic [OUT_IDX_W-1:0]   band_index;
      logic [OUT_COUNT_W-1:0] band_count;
      logic [OUT_COUNT_W-1:0] peak_count;
      logic                   last_band;
   } band_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;
      logic calc_luma;
      logic calc_scale;
      logic calc_band;
      logic mem_read;
      logic mem_write;
      logic dump_start;
      logic dump_step;
      logic clear;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic last_pixel;
      logic dump_end;
   } status_type;

endpackage

/* design/lhist_ctrl.sv */
module lhist_ctrl
   import lhist_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_LUMA  = 8'b0000_0010,
      ST_SCALE = 8'b0000_0100,
      ST_BAND  = 8'b0000_1000,
      ST_READ  = 8'b0001_0000,
      ST_WRITE = 8'b0010_0000,
      ST_DUMP  = 8'b0100_0000,
      ST_DRAIN = 8'b1000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_LUMA;
            end
         end
         ST_LUMA: begin
            cmd.calc_luma = 1'b1;
            state_in      = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.calc_scale = 1'b1;
            state_in       = ST_BAND;
         end
         ST_BAND: begin
            cmd.calc_band = 1'b1;
            state_in      = ST_READ;
         end
         ST_READ: begin
            cmd.mem_read = 1'b1;
            state_in     = ST_WRITE;
         end
         ST_WRITE: begin
            cmd.mem_write = 1'b1;
            if (status.last_pixel) begin
               cmd.dump_start = 1'b1;
               state_in       = ST_DUMP;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DUMP: begin
            cmd.dump_step = 1'b1;
            if (status.dump_end) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // last band is on the output this cycle; wipe the store behind it
            cmd.clear = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* design/lhist_dp.sv */
module lhist_dp
   import lhist_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  pixel_type        req_pixel,
   input  logic             csr_we,
   input  logic [LVL_W-1:0] csr_wdata,
   input  cmd_type          cmd,
   output status_type       status,
   output logic             rsp_strobe,
   output band_type         rsp_band
);

   pixel_type              pix_ff;
   logic [LVL_W-1:0]       levels_ff;
   logic [LUMA_W-1:0]      luma_ff;
   logic [PROD_W-1:0]      prod_ff;
   logic [IDX_W-1:0]       band_ff;
   logic [IDX_W-1:0]       dump_idx_ff;
   logic [COUNT_BITS-1:0]  mem_ff [MAX_LEVELS];
   logic [MAX_LEVELS-1:0]  vld_ff;
   logic [COUNT_BITS-1:0]  rd_data_ff;
   logic                   rd_vld_ff;
   logic [COUNT_BITS-1:0]  peak_ff;
   logic                   strobe_ff;
   logic [IDX_W-1:0]       out_idx_ff;
   logic                   out_last_ff;

   logic [LVL_W-1:0]       lvl;
   logic [LVL_W-1:0]       lvl_m1;
   logic [LUMA_W-1:0]      luma_in;
   logic [QUO_W-1:0]       quo;
   logic [EST_W-1:0]       est;
   logic [QUO_W-1:0]       rem;
   logic [LVL_W-1:0]       band_raw;
   logic [LVL_W-1:0]       band_clamped;
   logic [IDX_W-1:0]       rd_addr;
   logic [COUNT_BITS-1:0]  cur_count;
   logic [COUNT_BITS-1:0]  nxt_count;

   always_comb begin
      lvl = levels_ff;
      if (levels_ff == '0) begin
         lvl = LVL_W'(1);
      end else if (levels_ff > LEVELS_TOP) begin
         lvl = LEVELS_TOP;
      end
      lvl_m1 = lvl - LVL_W'(1);
   end

   assign luma_in = WEIGHT_RED   * LUMA_W'(pix_ff.red)
                  + WEIGHT_GREEN * LUMA_W'(pix_ff.green)
                  + WEIGHT_BLUE  * LUMA_W'(pix_ff.blue);

   // quo / 255 is quo >> 8 or one more; remainder check settles it
   always_comb begin
      quo      = prod_ff[PROD_W-1:FRAC_W];
      est      = quo[QUO_W-1:CHAN_W];
      rem      = quo - (QUO_W'(est) << CHAN_W) + QUO_W'(est);
      band_raw = LVL_W'(est) + LVL_W'(rem >= CHAN_FULL);
      band_clamped = (band_raw > lvl_m1) ? lvl_m1 : band_raw;
   end

   assign rd_addr   = cmd.mem_read ? band_ff : dump_idx_ff;
   assign cur_count = rd_vld_ff ? rd_data_ff : '0;
   assign nxt_count = (cur_count == COUNT_TOP) ? cur_count : cur_count + COUNT_BITS'(1);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         pix_ff <= req_pixel;
      end
      if (cmd.calc_luma) begin
         luma_ff <= luma_in;
      end
      if (cmd.calc_scale) begin
         prod_ff <= PROD_W'(lvl) * PROD_W'(luma_ff);
      end
      if (cmd.calc_band) begin
         band_ff <= band_clamped[IDX_W-1:0];
      end
      if (cmd.mem_read || cmd.dump_step) begin
         rd_data_ff <= mem_ff[rd_addr];
         rd_vld_ff  <= vld_ff[rd_addr];
         out_idx_ff <= dump_idx_ff;
         out_last_ff <= status.dump_end;
      end
      if (cmd.mem_write) begin
         mem_ff[band_ff] <= nxt_count;
      end
      if (cmd.dump_start) begin
         dump_idx_ff <= '0;
      end else if (cmd.dump_step) begin
         dump_idx_ff <= dump_idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         levels_ff <= LEVELS_RESET;
         vld_ff    <= '0;
         peak_ff   <= PEAK_RESET;
         strobe_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            levels_ff <= csr_wdata;
         end
         strobe_ff <= cmd.dump_step;
         if (cmd.clear) begin
            vld_ff  <= '0;
            peak_ff <= PEAK_RESET;
         end else if (cmd.mem_write) begin
            vld_ff[band_ff] <= 1'b1;
            if (nxt_count > peak_ff) begin
               peak_ff <= nxt_count;
            end
         end
      end
   end

   assign status.last_pixel = pix_ff.last_pixel;
   assign status.dump_end   = (dump_idx_ff == lvl_m1[IDX_W-1:0]);

   assign rsp_strobe          = strobe_ff;
   assign rsp_band.band_index = OUT_IDX_W'(out_idx_ff);
   assign rsp_band.band_count = cur_count[OUT_COUNT_W-1:0];
   assign rsp_band.peak_count = peak_ff[OUT_COUNT_W-1:0];
   assign rsp_band.last_band  = out_last_ff;

endmodule

/* design/luminance_histogram_core.sv */
// Luminance histogram core.
// Request channel: req_pixel (red, green, blue, last_pixel) is taken at a
// rising edge with start high and busy low. Each request then occupies the
// core through the luma, scale, band, counter read and counter write
// states, so the next pixel is accepted only once it is back in idle. The
// pacing is set by the controller stepping each pixel through the shared
// datapath and the read-modify-write of the single-port counter memory.
// On a request with last_pixel set, that pixel is counted, then one
// response per band 0..L-1 follows on rsp_band with rsp_strobe high for
// one cycle each, in back-to-back cycles, registered by readout steps after
// the counter write; last_band marks band L-1. The core stays busy until
// the last band is out; counters and peak are cleared as that cycle ends.
// Responses cannot be held off; the receiver must take each when strobed.
// csr_we/csr_wdata write num_levels (0 acts as 1, above 64 acts as 64);
// write only while busy is low.
// Reset (synchronous, active high) sets num_levels to 64, empties all
// bands and sets the peak to 1; counters use per-band valid bits, so no
// clearing pass is needed.
module luminance_histogram_core
   import lhist_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  pixel_type        req_pixel,
   input  logic             csr_we,
   input  logic [LVL_W-1:0] csr_wdata,
   output logic             rsp_strobe,
   output band_type         rsp_band
);

   cmd_type    cmd;
   status_type status;

   lhist_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   lhist_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_pixel  (req_pixel),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_band   (rsp_band)
   );

endmodule

/* design/lhist_checker.sv */
module lhist_checker
   import lhist_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_strobe,
   input band_type         rsp_band
);

   // responses only come out while a readout holds the core
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("response strobe while not busy");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("core not busy after accepting a request");

   a_burst_cont: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_band.last_band) |=>
         (rsp_strobe && rsp_band.band_index == 6'($past(rsp_band.band_index) + 6'd1)))
      else $error("readout burst broken or band index out of sequence");

   a_burst_peak: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_band.last_band) |=> $stable(rsp_band.peak_count))
      else $error("peak changed during readout");

   a_burst_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_band.last_band) |=> !rsp_strobe)
      else $error("response after last band");

endmodule

bind luminance_histogram_core lhist_checker u_lhist_checker (.*);

/* tb/sv/histogram_checker.sv */
`timescale 1ns / 1ps

module histogram_checker
   import lhist_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  pixel_type        req_pixel,
   input  logic             csr_we,
   input  logic [LVL_W-1:0] csr_wdata,
   input  logic             rsp_strobe,
   input  band_type         rsp_band,
   output int               mismatch_count,
   output int               bands_outstanding,
   output int               bands_checked
);

   localparam longint unsigned RED_WEIGHT   = 13938;
   localparam longint unsigned GREEN_WEIGHT = 46870;
   localparam longint unsigned BLUE_WEIGHT  = 4730;
   localparam longint unsigned FULL_SCALE   = 255 * 65536;
   localparam logic [23:0]     TALLY_TOP    = 24'hFFFFFF;

   logic [LVL_W-1:0] levels_setting;
   logic [23:0]      band_tally [64];
   logic [23:0]      peak_tally;
   band_type         expected_bands [$];

   initial begin
      mismatch_count    = 0;
      bands_outstanding = 0;
      bands_checked     = 0;
   end

   function automatic int active_levels();
      int lvl;
      lvl = int'(levels_setting);
      if (lvl < 1) lvl = 1;
      if (lvl > MAX_LEVELS) lvl = MAX_LEVELS;
      return lvl;
   endfunction

   function automatic void clear_tallies();
      foreach (band_tally[k]) band_tally[k] = '0;
      peak_tally = 24'd1;
   endfunction

   // Count one pixel; on the last pixel of an image queue the full readout.
   function automatic void tally_pixel(pixel_type px);
      longint unsigned luma;
      longint unsigned band;
      int              lvl;
      band_type        report;
      lvl  = active_levels();
      luma = RED_WEIGHT * px.red + GREEN_WEIGHT * px.green + BLUE_WEIGHT * px.blue;
      band = (longint'(lvl) * luma) / FULL_SCALE;
      // white lands past the top band
      if (band > longint'(lvl - 1)) band = lvl - 1;
      if (band_tally[band] != TALLY_TOP) band_tally[band] = band_tally[band] + 1'b1;
      if (band_tally[band] > peak_tally) peak_tally = band_tally[band];
      if (!px.last_pixel) return;
      for (int k = 0; k < lvl; k++) begin
         report.band_index = OUT_IDX_W'(k);
         report.band_count = band_tally[k];
         report.peak_count = peak_tally;
         report.last_band  = (k == lvl - 1);
         expected_bands.push_back(report);
      end
      clear_tallies();
   endfunction

   always @(posedge clock) begin
      band_type want;
      if (reset) begin
         levels_setting = LVL_W'(64);
         clear_tallies();
         expected_bands.delete();
      end else begin
         if (csr_we) levels_setting = csr_wdata;
         if (rsp_strobe) begin
            if (expected_bands.size() == 0) begin
               $error("unexpected band report: index %0d count %0d",
                      rsp_band.band_index, rsp_band.band_count);
               mismatch_count++;
            end else begin
               want = expected_bands.pop_front();
               bands_checked++;
               if (rsp_band.band_index !== want.band_index) begin
                  $error("band_index mismatch: expected %0d, got %0d",
                         want.band_index, rsp_band.band_index);
                  mismatch_count++;
               end
               if (rsp_band.band_count !== want.band_count) begin
                  $error("band_count mismatch: expected %0d, got %0d",
                         want.band_count, rsp_band.band_count);
                  mismatch_count++;
               end
               if (rsp_band.peak_count !== want.peak_count) begin
                  $error("peak_count mismatch: expected %0d, got %0d",
                         want.peak_count, rsp_band.peak_count);
                  mismatch_count++;
               end
               if (rsp_band.last_band !== want.last_band) begin
                  $error("last_band mismatch: expected %0d, got %0d",
                         want.last_band, rsp_band.last_band);
                  mismatch_count++;
               end
            end
         end
         if (start && !busy) tally_pixel(req_pixel);
      end
      bands_outstanding = expected_bands.size();
   end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
   import lhist_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 8;
   localparam int DRAIN_CYCLES   = 24;
   localparam int RANDOM_PIXELS  = 240;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             start     = 1'b0;
   logic             csr_we    = 1'b0;
   logic [LVL_W-1:0] csr_wdata = '0;
   pixel_type        req_pixel = '0;
   logic             busy;
   logic             rsp_strobe;
   band_type         rsp_band;

   int mismatch_count;
   int bands_outstanding;
   int bands_checked;
   int pixels_sent   = 0;
   int images_sent   = 0;
   int settings_used = 0;
   int idle_cycles   = 0;

   luminance_histogram_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_pixel  (req_pixel),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .rsp_strobe (rsp_strobe),
      .rsp_band   (rsp_band)
   );

   histogram_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_pixel         (req_pixel),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata),
      .rsp_strobe        (rsp_strobe),
      .rsp_band          (rsp_band),
      .mismatch_count    (mismatch_count),
      .bands_outstanding (bands_outstanding),
      .bands_checked     (bands_checked)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((start && !busy) || rsp_strobe || csr_we) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   function automatic pixel_type rgb(int r, int g, int b, logic last);
      pixel_type px;
      px.red        = CHAN_W'(r);
      px.green      = CHAN_W'(g);
      px.blue       = CHAN_W'(b);
      px.last_pixel = last;
      return px;
   endfunction

   function automatic pixel_type random_pixel(logic last);
      int level;
      case ($urandom_range(0, 9))
         0: return rgb($urandom_range(0, 1) * 255, $urandom_range(0, 1) * 255,
                       $urandom_range(0, 1) * 255, last);
         1: begin
            level = $urandom_range(0, 255);
            return rgb(level, level, level, last);
         end
         2: return rgb($urandom_range(240, 255), $urandom_range(240, 255),
                       $urandom_range(240, 255), last);
         default: return rgb($urandom_range(0, 255), $urandom_range(0, 255),
                             $urandom_range(0, 255), last);
      endcase
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [LVL_W-1:0] pick_levels();
      case ($urandom_range(0, 7))
         0: return LVL_W'(1);
         1: return LVL_W'(64);
         2: return LVL_W'($urandom_range(65, 127));
         3: return LVL_W'(0);
         default: return LVL_W'($urandom_range(1, 64));
      endcase
   endfunction

   task automatic send_pixel(input pixel_type px, input int gap);
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start     <= 1'b1;
      req_pixel <= px;
      do @(posedge clock); while (busy);
      pixels_sent++;
      if (px.last_pixel) images_sent++;
   endtask

   // Hold requests until the readout has drained and the core has gone idle.
   task automatic write_levels(input logic [LVL_W-1:0] value);
      @(negedge clock);
      start <= 1'b0;
      while (bands_outstanding != 0 || busy) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   task automatic send_image(input int length);
      logic back_to_back;
      back_to_back = ($urandom_range(0, 9) < 3);
      for (int i = 0; i < length; i++) begin
         // occasional band change in the middle of an image
         if (length > 4 && i == length / 2 && $urandom_range(0, 9) == 0)
            write_levels(pick_levels());
         send_pixel(random_pixel(i == length - 1), back_to_back ? 0 : pick_gap());
      end
   endtask

   initial begin
      int target;
      int image_length;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset setting of 64 bands: corners, primaries, white clamp
      send_pixel(rgb(0, 0, 0, 1'b0), 0);
      send_pixel(rgb(255, 255, 255, 1'b0), 0);
      send_pixel(rgb(255, 0, 0, 1'b0), 1);
      send_pixel(rgb(0, 255, 0, 1'b0), 0);
      send_pixel(rgb(0, 0, 255, 1'b0), 2);
      send_pixel(rgb(128, 128, 128, 1'b1), 0);

      // zero acts as one band
      write_levels(LVL_W'(0));
      send_pixel(rgb(255, 255, 255, 1'b1), 0);
      send_pixel(rgb(0, 0, 0, 1'b1), 0);

      // above the top acts as 64
      write_levels(LVL_W'(127));
      send_pixel(rgb(1, 2, 3, 1'b1), 0);

      // shrink bands mid-image: band 63 keeps its count and feeds the peak
      write_levels(LVL_W'(64));
      send_pixel(rgb(255, 255, 255, 1'b0), 0);
      send_pixel(rgb(255, 255, 255, 1'b0), 0);
      send_pixel(rgb(255, 255, 255, 1'b0), 0);
      write_levels(LVL_W'(4));
      send_pixel(rgb(0, 0, 0, 1'b0), 0);
      send_pixel(rgb(200, 10, 90, 1'b1), 0);
      write_levels(LVL_W'(64));
      send_pixel(rgb(0, 0, 0, 1'b1), 0);

      // just either side of the halfway edge
      write_levels(LVL_W'(2));
      send_pixel(rgb(127, 127, 127, 1'b0), 0);
      send_pixel(rgb(128, 128, 128, 1'b1), 0);

      target = pixels_sent + RANDOM_PIXELS;
      while (pixels_sent < target) begin
         write_levels(pick_levels());
         repeat ($urandom_range(1, 3)) begin
            image_length = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                       : $urandom_range(1, 10);
            send_image(image_length);
         end
      end

      @(negedge clock);
      start <= 1'b0;
      while (bands_outstanding != 0 || busy) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Run covered %0d pixels in %0d images across %0d band settings,",
               pixels_sent, images_sent, settings_used);
      $display("with %0d band reports compared against the prediction.", bands_checked);
      if (mismatch_count == 0 && bands_outstanding == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
